@@ hdl/all_pairs_shortest_path_defines.svh @@
// assertion macros for the all-pairs shortest-path block
// used by modules that carry concurrent checks; needs clk_i and rst_ni in scope
`ifndef ALL_PAIRS_SHORTEST_PATH_DEFINES_SVH
`define ALL_PAIRS_SHORTEST_PATH_DEFINES_SVH

// check that is off while reset is asserted
`define APSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that also holds during reset
`define APSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/apsp_pkg.sv @@
// shared types and constants of the all-pairs shortest-path block
// no dependencies
package apsp_pkg;

  localparam int MaxNodes = 64;
  localparam int IdxW     = $clog2(MaxNodes);
  localparam int AddrW    = 2 * IdxW;
  localparam int Depth    = MaxNodes * MaxNodes;
  localparam int CntW     = 7;
  localparam int DistW    = 23;
  localparam int OutW     = 22;
  localparam int WeightW  = 16;

  localparam logic [DistW-1:0] DistInf      = 23'h400000;
  localparam logic [CntW-1:0]  NodeCountRst = 7'd64;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_RUN   = 2'd2,
    FUNC_QUERY = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_LDA,
    ST_LDB,
    ST_QRD,
    ST_PLD,
    ST_RROW,
    ST_UPD,
    ST_DRN,
    ST_FIN
  } state_e;

  // what the read issued last cycle returns this cycle
  typedef enum logic [2:0] {
    RD_NONE,
    RD_PIV,
    RD_RP,
    RD_UPD,
    RD_QRY
  } rd_kind_e;

  typedef struct packed {
    logic shift;
    logic tail;
  } cell_ctrl_t;

endpackage

@@ hdl/apsp_ram.sv @@
// generic single-write, single-read memory with registered read data
// no dependencies
module apsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/apsp_cell.sv @@
// one cell of the pivot-row chain: holds one distance, shifts toward the head
// depends on apsp_pkg
module apsp_cell (
  input  logic                      clk_i,
  input  apsp_pkg::cell_ctrl_t      ctrl_i,
  input  logic [apsp_pkg::DistW-1:0] feed_i,
  input  logic [apsp_pkg::DistW-1:0] nbr_i,
  output logic [apsp_pkg::DistW-1:0] data_o
);

  logic [apsp_pkg::DistW-1:0] data_q;
  logic [apsp_pkg::DistW-1:0] data_d;

  // the tail cell takes new data, the others take their neighbor's
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift) begin
      data_d = ctrl_i.tail ? feed_i : nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ hdl/all_pairs_shortest_path.sv @@
// all-pairs shortest-path engine: sequencer, distance memory, pivot-row chain
// depends on apsp_pkg, apsp_ram, apsp_cell and all_pairs_shortest_path_defines.svh
//
//  channel | handshake               | payload
//  in      | in_valid_i / in_stall_o | func_i node_a_i node_b_i edge_weight_i
//  out     | out_valid_o/ out_stall_i| distance_o reachable_o op_echo_o
//  cfg     | cfg_valid_i/ cfg_ready_o| cfg_data_i (node_count)
//
// clear writes all 4096 entries, one a cycle; load writes two entries; query reads one
// run with n nodes: for each pivot load its row, then for each row read its pivot entry and
// update every column, one memory read per cycle; the pivot row sits in the cell chain;
// each update reads and writes one entry; the memory holds garbage after reset until a clear
// a finished result waits in the output register; the next transaction is taken meanwhile
`include "all_pairs_shortest_path_defines.svh"

module all_pairs_shortest_path (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [5:0]  node_a_i,
  input  logic [5:0]  node_b_i,
  input  logic [15:0] edge_weight_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [21:0] distance_o,
  output logic        reachable_o,
  output logic [1:0]  op_echo_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);

  localparam int N  = apsp_pkg::MaxNodes;
  localparam int IW = apsp_pkg::IdxW;
  localparam int AW = apsp_pkg::AddrW;
  localparam int DW = apsp_pkg::DistW;
  localparam int CW = apsp_pkg::CntW;

  apsp_pkg::state_e   state_q, state_d;
  apsp_pkg::rd_kind_e rd_kind_q, rd_kind_d;
  logic [AW-1:0]      rd_addr_q, rd_addr_d;

  logic [CW-1:0] node_count_q;
  logic [CW-1:0] cnt;
  logic [IW-1:0] p_q, r_q, c_q;
  logic [AW-1:0] clr_q;
  logic [IW-1:0] a_q, b_q;
  logic [apsp_pkg::WeightW-1:0] w_q;
  logic [1:0]    op_q;
  logic [apsp_pkg::OutW-1:0] res_dist_q;
  logic          res_reach_q;
  logic [DW-1:0] rp_q;

  logic          out_valid_q;
  logic [apsp_pkg::OutW-1:0] out_dist_q;
  logic          out_reach_q;
  logic [1:0]    out_op_q;

  logic          in_acc;
  logic          last_c, last_r, last_p, last_clr, out_free;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic          rd_issue;

  logic [DW-1:0] head;
  logic [DW-1:0] feed;
  logic [DW-1:0] via;
  logic [DW-1:0] sum;
  logic [DW-1:0] upd_val;
  logic [DW-1:0] cell_data [N];
  logic          chain_shift;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != apsp_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign cnt      = (node_count_q > CW'(N)) ? CW'(N) : node_count_q;
  assign last_c   = ({1'b0, c_q} == cnt - CW'(1));
  assign last_r   = ({1'b0, r_q} == cnt - CW'(1));
  assign last_p   = ({1'b0, p_q} == cnt - CW'(1));
  assign last_clr = (clr_q == AW'(apsp_pkg::Depth - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      apsp_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (apsp_pkg::func_e'(func_i))
            apsp_pkg::FUNC_CLEAR: state_d = apsp_pkg::ST_CLR;
            apsp_pkg::FUNC_LOAD:  state_d = apsp_pkg::ST_LDA;
            apsp_pkg::FUNC_RUN:   state_d = (cnt == '0) ? apsp_pkg::ST_FIN : apsp_pkg::ST_PLD;
            default:              state_d = apsp_pkg::ST_QRD;
          endcase
        end
      end
      apsp_pkg::ST_CLR:  if (last_clr) state_d = apsp_pkg::ST_FIN;
      apsp_pkg::ST_LDA:  state_d = apsp_pkg::ST_LDB;
      apsp_pkg::ST_LDB:  state_d = apsp_pkg::ST_FIN;
      apsp_pkg::ST_QRD:  state_d = apsp_pkg::ST_DRN;
      apsp_pkg::ST_PLD:  if (last_c) state_d = apsp_pkg::ST_RROW;
      apsp_pkg::ST_RROW: state_d = apsp_pkg::ST_UPD;
      apsp_pkg::ST_UPD: begin
        if (last_c) begin
          if (!last_r) begin
            state_d = apsp_pkg::ST_RROW;
          end else if (last_p) begin
            state_d = apsp_pkg::ST_DRN;
          end else begin
            state_d = apsp_pkg::ST_PLD;
          end
        end
      end
      apsp_pkg::ST_DRN:  state_d = apsp_pkg::ST_FIN;
      apsp_pkg::ST_FIN:  if (out_free) state_d = apsp_pkg::ST_IDLE;
      default:           state_d = apsp_pkg::ST_IDLE;
    endcase
  end

  // memory reads issued by the sequencer
  always_comb begin
    rd_kind_d = apsp_pkg::RD_NONE;
    rd_addr_d = {r_q, c_q};
    case (state_q)
      apsp_pkg::ST_QRD: begin
        rd_kind_d = apsp_pkg::RD_QRY;
        rd_addr_d = {a_q, b_q};
      end
      apsp_pkg::ST_PLD: begin
        rd_kind_d = apsp_pkg::RD_PIV;
        rd_addr_d = {p_q, c_q};
      end
      apsp_pkg::ST_RROW: begin
        rd_kind_d = apsp_pkg::RD_RP;
        rd_addr_d = {r_q, p_q};
      end
      apsp_pkg::ST_UPD: begin
        rd_kind_d = apsp_pkg::RD_UPD;
        rd_addr_d = {r_q, c_q};
      end
      default: begin
        rd_kind_d = apsp_pkg::RD_NONE;
      end
    endcase
  end

  assign ram_raddr = rd_addr_d;
  assign rd_issue  = (rd_kind_d != apsp_pkg::RD_NONE);

  // saturating relaxation through the pivot
  assign head = cell_data[0];
  assign sum  = DW'({1'b0, rp_q[DW-2:0]} + {1'b0, head[DW-2:0]});
  assign via  = (rp_q[DW-1] || head[DW-1] || sum[DW-1]) ? apsp_pkg::DistInf : sum;
  assign upd_val = (via < ram_rdata) ? via : ram_rdata;

  // memory writes
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_addr_q;
    ram_wdata = upd_val;
    case (state_q)
      apsp_pkg::ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = (clr_q[AW-1:IW] == clr_q[IW-1:0]) ? '0 : apsp_pkg::DistInf;
      end
      apsp_pkg::ST_LDA: begin
        ram_we    = 1'b1;
        ram_waddr = {a_q, b_q};
        ram_wdata = DW'(w_q);
      end
      apsp_pkg::ST_LDB: begin
        ram_we    = 1'b1;
        ram_waddr = {b_q, a_q};
        ram_wdata = DW'(w_q);
      end
      default: begin
        ram_we = (rd_kind_q == apsp_pkg::RD_UPD);
      end
    endcase
  end

  apsp_ram #(
    .Width (DW),
    .Depth (apsp_pkg::Depth)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // pivot row chain: loads from memory, rotates once per update
  assign chain_shift = (rd_kind_q == apsp_pkg::RD_PIV) || (rd_kind_q == apsp_pkg::RD_UPD);
  assign feed        = (rd_kind_q == apsp_pkg::RD_PIV) ? ram_rdata : head;

  for (genvar i = 0; i < N; i++) begin : g_cell
    apsp_pkg::cell_ctrl_t ctrl;
    logic [DW-1:0]        nbr;
    assign ctrl.shift = chain_shift;
    assign ctrl.tail  = (CW'(i) == cnt - CW'(1));
    if (i == N - 1) begin : g_end
      assign nbr = feed;
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end
    apsp_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .feed_i (feed),
      .nbr_i  (nbr),
      .data_o (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= apsp_pkg::ST_IDLE;
      rd_kind_q    <= apsp_pkg::RD_NONE;
      node_count_q <= apsp_pkg::NodeCountRst;
      out_valid_q  <= 1'b0;
      p_q          <= '0;
      r_q          <= '0;
      c_q          <= '0;
      clr_q        <= '0;
    end else begin
      state_q   <= state_d;
      rd_kind_q <= rd_kind_d;
      if (cfg_valid_i && cfg_ready_o) begin
        node_count_q <= cfg_data_i;
      end
      if (state_q == apsp_pkg::ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        p_q   <= '0;
        r_q   <= '0;
        c_q   <= '0;
        clr_q <= '0;
      end
      if (state_q == apsp_pkg::ST_CLR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (state_q == apsp_pkg::ST_PLD) begin
        c_q <= last_c ? '0 : c_q + IW'(1);
      end
      if (state_q == apsp_pkg::ST_UPD) begin
        c_q <= last_c ? '0 : c_q + IW'(1);
        if (last_c) begin
          if (last_r) begin
            r_q <= '0;
            p_q <= p_q + IW'(1);
          end else begin
            r_q <= r_q + IW'(1);
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    if (in_acc) begin
      a_q         <= node_a_i;
      b_q         <= node_b_i;
      w_q         <= edge_weight_i;
      op_q        <= func_i;
      res_dist_q  <= '0;
      res_reach_q <= 1'b0;
    end
    if (rd_kind_q == apsp_pkg::RD_QRY && !ram_rdata[DW-1]) begin
      res_dist_q  <= ram_rdata[DW-2:0];
      res_reach_q <= 1'b1;
    end
    if (rd_kind_q == apsp_pkg::RD_RP) begin
      rp_q <= ram_rdata;
    end
    if (state_q == apsp_pkg::ST_FIN && out_free) begin
      out_dist_q  <= res_dist_q;
      out_reach_q <= res_reach_q;
      out_op_q    <= op_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = out_dist_q;
  assign reachable_o = out_reach_q;
  assign op_echo_o   = out_op_q;

  `APSP_ASSERT(a_no_rw_collide, ram_we && rd_issue |-> ram_waddr != ram_raddr, "read and write hit the same entry")
  `APSP_ASSERT(a_col_in_range, state_q == apsp_pkg::ST_UPD |-> {1'b0, c_q} < cnt, "column counter beyond node count")
  `APSP_ASSERT(a_fin_gives_result, state_q == apsp_pkg::ST_FIN && out_free |=> out_valid_q && state_q == apsp_pkg::ST_IDLE, "finished item did not reach the output register")
  `APSP_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |-> in_stall_o == (state_q != apsp_pkg::ST_IDLE), "stall not tied to sequencer")

endmodule
